[rtl/m3i_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] a00;
        logic signed [DATA_W-1:0] a01;
        logic signed [DATA_W-1:0] a02;
        logic signed [DATA_W-1:0] a10;
        logic signed [DATA_W-1:0] a11;
        logic signed [DATA_W-1:0] a12;
        logic signed [DATA_W-1:0] a20;
        logic signed [DATA_W-1:0] a21;
        logic signed [DATA_W-1:0] a22;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] r00;
        logic signed [DATA_W-1:0] r01;
        logic signed [DATA_W-1:0] r02;
        logic signed [DATA_W-1:0] r10;
        logic signed [DATA_W-1:0] r11;
        logic signed [DATA_W-1:0] r12;
        logic signed [DATA_W-1:0] r20;
        logic signed [DATA_W-1:0] r21;
        logic signed [DATA_W-1:0] r22;
        logic signed [DATA_W-1:0] det_out;
        logic                     singular;
        logic                     overflow;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/m3i_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, with a quotient overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module m3i_divider #(
    parameter int NUM_W = 97,
    parameter int DEN_W = 99,
    parameter int QUO_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo,
    output logic                  o_big
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0] r_rem [0:QUO_W-1];
    logic [QUO_W-1:0] r_lo  [0:QUO_W-1];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_big [0:QUO_W];

    logic [DEN_W-1:0] n_hi;
    logic             n_big;
    logic [DEN_W:0]   n_t    [0:QUO_W-1];
    logic [DEN_W+1:0] n_diff [0:QUO_W-1];
    logic             n_ge   [0:QUO_W-1];

    // The upper numerator bits must be below the divisor, or the quotient
    // needs more than QUO_W bits.
    assign n_hi  = {{(DEN_W-HI_W){1'b0}}, i_num[NUM_W-1:QUO_W]};
    assign n_big = (n_hi >= i_den);

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            n_t[k]    = {r_rem[k], r_lo[k][QUO_W-1]};
            n_diff[k] = {1'b0, n_t[k]} - {2'b00, r_den[k]};
            n_ge[k]   = !n_diff[k][DEN_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_big ? '0 : n_hi;
            r_lo[0]  <= i_num[QUO_W-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_big[0] <= n_big;
            for (int k = 0; k < QUO_W - 1; k++) begin
                r_rem[k+1] <= n_ge[k] ? n_diff[k][DEN_W-1:0] : n_t[k][DEN_W-1:0];
                r_lo[k+1]  <= {r_lo[k][QUO_W-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
            end
            for (int k = 0; k < QUO_W; k++) begin
                r_q[k+1]   <= {r_q[k][QUO_W-2:0], n_ge[k]};
                r_big[k+1] <= r_big[k];
            end
        end
    end

    assign o_quo = r_q[QUO_W];
    assign o_big = r_big[QUO_W];

endmodule
`default_nettype wire

[rtl/matrix3_inverse.sv]
// Top level of the 3x3 matrix inverse: cofactors, determinant, nine dividers, output skid.
//
//   channel | handshake         | payload
//   --------+-------------------+------------------------------
//   input   | i_valid / o_stall | i_item (nine Q16.16 elements)
//   output  | o_valid / i_stall | o_item (inverse, det, flags)
//
// One item enters per cycle while o_stall is low; the longest part of the
// pipeline is the divider, which retires one quotient bit per stage.
// Reset clears only the valid bits and the skid flag.
// A stall at the output parks one item in the skid register; the pipeline
// freezes only while that register is full.
`timescale 1ns / 1ps
`default_nettype none
module matrix3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire m3i_pkg::t_in_item   i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output m3i_pkg::t_out_item       o_item
);
    import m3i_pkg::*;

    localparam int W   = DATA_W;
    localparam int PW  = 2 * W;
    localparam int AW  = 2 * W + 1;
    localparam int DTW = 3 * W + 3;
    localparam int NW  = AW + 2 * FRAC_BITS;
    localparam int LAT = W + 1;
    localparam logic [W-1:0] CAP_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] CAP_NEG = {1'b1, {(W-1){1'b0}}};

    // Stage valid bits.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic r_dv [0:LAT-1];

    // Stage 1: input register.
    t_in_item r1_item;
    // Stage 2: pair products.
    logic signed [PW-1:0] r2_p  [0:17];
    logic signed [W-1:0]  r2_a0 [0:2];
    // Stage 3: adjugate.
    logic signed [AW-1:0] r3_adj [0:8];
    logic signed [W-1:0]  r3_a0  [0:2];
    // Stage 4: split products of the row-0 expansion.
    logic signed [AW-1:0] r4_pl  [0:2];
    logic signed [AW-1:0] r4_ph  [0:2];
    logic signed [AW-1:0] r4_adj [0:8];
    // Stage 5: expansion terms.
    logic signed [DTW-1:0] r5_t   [0:2];
    logic signed [AW-1:0]  r5_adj [0:8];
    // Stage 6: determinant.
    logic signed [DTW-1:0] r6_det;
    logic signed [AW-1:0]  r6_adj [0:8];
    // Stage 7: magnitudes and signs.
    logic [NW-1:0]  r7_num [0:8];
    logic [DTW-1:0] r7_dabs;
    logic [8:0]     r7_neg;
    logic           r7_sing;
    logic [W-1:0]   r7_det;
    logic           r7_dovf;
    // Side data that travels beside the dividers.
    logic [8:0]   r_dneg  [0:LAT-1];
    logic         r_dsing [0:LAT-1];
    logic [W-1:0] r_ddet  [0:LAT-1];
    logic         r_ddovf [0:LAT-1];

    logic      r_out_valid, r_skid_full;
    t_out_item r_out, r_skid, n_res;

    logic en;
    assign en = !r_skid_full;

    logic signed [AW-1:0] n_adj [0:8];
    logic signed [AW-1:0] n_pl  [0:2];
    logic signed [AW-1:0] n_ph  [0:2];
    logic [AW-1:0]        n_aabs [0:8];
    logic [DTW-1:0]       n_dabs, n_sh;
    logic                 n_dneg, n_dover;
    logic [W-1:0]         n_dcap, n_detv;
    logic [W-1:0]         n_quo [0:8];
    logic                 n_big [0:8];
    logic [W-1:0]         n_el  [0:8];
    logic [8:0]           n_eovf;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_adj[k] = AW'(r2_p[2*k]) - AW'(r2_p[2*k+1]);
        end
        for (int j = 0; j < 3; j++) begin
            n_pl[j] = r3_a0[j] * $signed({1'b0, r3_adj[3*j][W-1:0]});
            n_ph[j] = r3_a0[j] * $signed(r3_adj[3*j][AW-1:W]);
        end
        n_dneg = r6_det[DTW-1];
        n_dabs = n_dneg ? DTW'(-r6_det) : DTW'(r6_det);
        for (int k = 0; k < 9; k++) begin
            n_aabs[k] = r6_adj[k][AW-1] ? AW'(-r6_adj[k]) : AW'(r6_adj[k]);
        end
        n_sh    = n_dabs >> (2 * FRAC_BITS);
        n_dcap  = n_dneg ? CAP_NEG : CAP_POS;
        n_dover = n_sh > DTW'(n_dcap);
        if (n_dover) begin
            n_detv = n_dcap;
        end else if (n_dneg) begin
            n_detv = W'(0) - n_sh[W-1:0];
        end else begin
            n_detv = n_sh[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            for (int k = 0; k < LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_v6    <= r_v5;
            r_v7    <= r_v6;
            r_dv[0] <= r_v7;
            for (int k = 1; k < LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_item <= i_item;

            r2_p[0]  <= r1_item.a11 * r1_item.a22;
            r2_p[1]  <= r1_item.a12 * r1_item.a21;
            r2_p[2]  <= r1_item.a02 * r1_item.a21;
            r2_p[3]  <= r1_item.a01 * r1_item.a22;
            r2_p[4]  <= r1_item.a01 * r1_item.a12;
            r2_p[5]  <= r1_item.a02 * r1_item.a11;
            r2_p[6]  <= r1_item.a12 * r1_item.a20;
            r2_p[7]  <= r1_item.a10 * r1_item.a22;
            r2_p[8]  <= r1_item.a00 * r1_item.a22;
            r2_p[9]  <= r1_item.a02 * r1_item.a20;
            r2_p[10] <= r1_item.a02 * r1_item.a10;
            r2_p[11] <= r1_item.a00 * r1_item.a12;
            r2_p[12] <= r1_item.a10 * r1_item.a21;
            r2_p[13] <= r1_item.a11 * r1_item.a20;
            r2_p[14] <= r1_item.a01 * r1_item.a20;
            r2_p[15] <= r1_item.a00 * r1_item.a21;
            r2_p[16] <= r1_item.a00 * r1_item.a11;
            r2_p[17] <= r1_item.a01 * r1_item.a10;
            r2_a0[0] <= r1_item.a00;
            r2_a0[1] <= r1_item.a01;
            r2_a0[2] <= r1_item.a02;

            r3_adj <= n_adj;
            r3_a0  <= r2_a0;

            // The determinant is expanded along row 0 with the first adjugate
            // column, which equals the rule of Sarrus exactly.
            r4_pl  <= n_pl;
            r4_ph  <= n_ph;
            r4_adj <= r3_adj;

            for (int j = 0; j < 3; j++) begin
                r5_t[j] <= (DTW'(r4_ph[j]) <<< W) + DTW'(r4_pl[j]);
            end
            r5_adj <= r4_adj;

            r6_det <= r5_t[0] + r5_t[1] + r5_t[2];
            r6_adj <= r5_adj;

            for (int k = 0; k < 9; k++) begin
                r7_num[k] <= {n_aabs[k], {(2*FRAC_BITS){1'b0}}};
                r7_neg[k] <= r6_adj[k][AW-1] ^ n_dneg;
            end
            r7_dabs <= n_dabs;
            r7_sing <= (r6_det == '0);
            r7_det  <= n_detv;
            r7_dovf <= n_dover;

            r_dneg[0]  <= r7_neg;
            r_dsing[0] <= r7_sing;
            r_ddet[0]  <= r7_det;
            r_ddovf[0] <= r7_dovf;
            for (int k = 1; k < LAT; k++) begin
                r_dneg[k]  <= r_dneg[k-1];
                r_dsing[k] <= r_dsing[k-1];
                r_ddet[k]  <= r_ddet[k-1];
                r_ddovf[k] <= r_ddovf[k-1];
            end
        end
    end

    for (genvar g = 0; g < 9; g++) begin : g_div
        m3i_divider #(
            .NUM_W (NW),
            .DEN_W (DTW),
            .QUO_W (W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r7_num[g]),
            .i_den (r7_dabs),
            .o_quo (n_quo[g]),
            .o_big (n_big[g])
        );
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (n_big[k] || (n_quo[k] > (r_dneg[LAT-1][k] ? CAP_NEG : CAP_POS))) begin
                n_el[k]   = r_dneg[LAT-1][k] ? CAP_NEG : CAP_POS;
                n_eovf[k] = 1'b1;
            end else begin
                n_el[k]   = r_dneg[LAT-1][k] ? W'(0) - n_quo[k] : n_quo[k];
                n_eovf[k] = 1'b0;
            end
            if (r_dsing[LAT-1]) begin
                n_el[k] = '0;
            end
        end
        n_res.r00      = n_el[0];
        n_res.r01      = n_el[1];
        n_res.r02      = n_el[2];
        n_res.r10      = n_el[3];
        n_res.r11      = n_el[4];
        n_res.r12      = n_el[5];
        n_res.r20      = n_el[6];
        n_res.r21      = n_el[7];
        n_res.r22      = n_el[8];
        n_res.det_out  = r_dsing[LAT-1] ? '0 : r_ddet[LAT-1];
        n_res.singular = r_dsing[LAT-1];
        n_res.overflow = !r_dsing[LAT-1] && (r_ddovf[LAT-1] || (n_eovf != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (!i_stall) begin
                r_skid_full <= 1'b0;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= r_dv[LAT-1];
        end else if (r_dv[LAT-1]) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out <= n_res;
        end else begin
            r_skid <= n_res;
        end
    end

    assign o_stall = r_skid_full;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
`default_nettype wire

[bench/inverse_checker.sv]
// Checker for the 3x3 matrix inverse: predicts each inverse and compares it with the block's output.
`timescale 1ns / 1ps
module inverse_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  m3i_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  m3i_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending
);
    import m3i_pkg::*;

    localparam int FRAC = 16;
    localparam int WIDE = 192;

    typedef logic signed [WIDE-1:0] t_wide;
    typedef logic [WIDE-1:0]        t_mag;

    t_out_item expected_inverses[$];
    int        fail_count = 0;
    int        report_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_inverses.size();

    function automatic t_wide widen(logic [DATA_W-1:0] v);
        return {{(WIDE-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic t_mag magnitude(t_wide v);
        return v[WIDE-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

    // Clamps a magnitude with sign to the element range and flags any clamping.
    function automatic logic [DATA_W-1:0] clamp(t_mag mag, logic neg, inout logic ovf);
        t_mag cap;
        cap = neg ? (t_mag'(1) << (DATA_W-1)) : ((t_mag'(1) << (DATA_W-1)) - 1);
        if (mag > cap) begin
            ovf = 1'b1;
            return neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return neg ? -mag[DATA_W-1:0] : mag[DATA_W-1:0];
    endfunction

    function automatic t_out_item predict_inverse(t_in_item m);
        t_wide a [3][3];
        t_wide adj [3][3];
        t_wide det;
        t_mag  det_mag;
        logic  ovf;
        logic [DATA_W-1:0] elem [9];
        t_out_item r;
        a[0][0] = widen(m.a00); a[0][1] = widen(m.a01); a[0][2] = widen(m.a02);
        a[1][0] = widen(m.a10); a[1][1] = widen(m.a11); a[1][2] = widen(m.a12);
        a[2][0] = widen(m.a20); a[2][1] = widen(m.a21); a[2][2] = widen(m.a22);
        det = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0] + a[0][2]*a[1][0]*a[2][1]
            - a[0][2]*a[1][1]*a[2][0] - a[0][0]*a[1][2]*a[2][1] - a[0][1]*a[1][0]*a[2][2];
        adj[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
        adj[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
        adj[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
        adj[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
        adj[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
        adj[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
        adj[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
        adj[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
        adj[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        ovf = 1'b0;
        det_mag = magnitude(det);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                elem[i*3+j] = clamp((magnitude(adj[i][j]) << (2*FRAC)) / det_mag,
                                    adj[i][j][WIDE-1] ^ det[WIDE-1], ovf);
            end
        end
        r.r00 = elem[0]; r.r01 = elem[1]; r.r02 = elem[2];
        r.r10 = elem[3]; r.r11 = elem[4]; r.r12 = elem[5];
        r.r20 = elem[6]; r.r21 = elem[7]; r.r22 = elem[8];
        r.det_out  = clamp(det_mag >> (2*FRAC), det[WIDE-1], ovf);
        r.overflow = ovf;
        return r;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got,
                               inout logic bad);
        if (got !== want) begin
            bad = 1'b1;
            if (report_count < 10)
                $display("mismatch %s: expected %h actual %h at %0t", name, want, got, $realtime);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        logic      bad;
        if (i_rst_n && i_in_valid && !i_in_stall)
            expected_inverses.push_back(predict_inverse(i_in_item));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_inverses.size() == 0) begin
                fail_count++;
                if (report_count < 10)
                    $display("unexpected result %h at %0t", i_out_item, $realtime);
                report_count++;
            end else begin
                want = expected_inverses.pop_front();
                bad  = 1'b0;
                check_field("r00", want.r00, i_out_item.r00, bad);
                check_field("r01", want.r01, i_out_item.r01, bad);
                check_field("r02", want.r02, i_out_item.r02, bad);
                check_field("r10", want.r10, i_out_item.r10, bad);
                check_field("r11", want.r11, i_out_item.r11, bad);
                check_field("r12", want.r12, i_out_item.r12, bad);
                check_field("r20", want.r20, i_out_item.r20, bad);
                check_field("r21", want.r21, i_out_item.r21, bad);
                check_field("r22", want.r22, i_out_item.r22, bad);
                check_field("det_out", want.det_out, i_out_item.det_out, bad);
                check_field("singular", DATA_W'(want.singular), DATA_W'(i_out_item.singular), bad);
                check_field("overflow", DATA_W'(want.overflow), DATA_W'(i_out_item.overflow), bad);
                if (bad) begin
                    fail_count++;
                    report_count++;
                end
            end
        end
    end
endmodule

[bench/tb_top.sv]
// Testbench top for the 3x3 matrix inverse: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
    import m3i_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_LIMIT   = 4000;
    localparam logic [DATA_W-1:0] ONE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MINV = 32'h8000_0000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    t_in_item   i_item = '0;
    logic       o_stall;
    logic       o_valid;
    t_out_item  o_item;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         cycle = 0;
    int         stall_mode = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    matrix3_inverse i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    inverse_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_item(i_item),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_item(o_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The output side cycles through no stalls, sparse stalls, heavy stalls and long blocks.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 2);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= ((cycle / 16) % 3 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand_elem(int kind);
        case (kind)
            0: return $urandom();
            1: return DATA_W'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
            2: return DATA_W'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
            3: return DATA_W'($signed($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 4))
                    0: return MAXV;
                    1: return MINV;
                    2: return ONE;
                    3: return -ONE;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic t_in_item make_matrix(logic [DATA_W-1:0] e [9]);
        t_in_item m;
        m.a00 = e[0]; m.a01 = e[1]; m.a02 = e[2];
        m.a10 = e[3]; m.a11 = e[4]; m.a12 = e[5];
        m.a20 = e[6]; m.a21 = e[7]; m.a22 = e[8];
        return m;
    endfunction

    function automatic t_in_item random_matrix();
        logic [DATA_W-1:0] e [9];
        int kind;
        int shape;
        kind  = $urandom_range(0, 4);
        shape = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
            e[k] = rand_elem(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : kind);
        if (shape == 0) begin
            // Dependent rows give a singular matrix.
            for (int k = 0; k < 3; k++)
                e[6+k] = e[k];
        end else if (shape == 1) begin
            for (int k = 0; k < 3; k++)
                e[3+k] = -e[k];
        end else if (shape == 2) begin
            e[1] = '0; e[2] = '0; e[3] = '0; e[5] = '0; e[6] = '0; e[7] = '0;
        end
        return make_matrix(e);
    endfunction

    task automatic send_matrix(t_in_item m);
        i_valid <= 1'b1;
        i_item  <= m;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    function automatic t_in_item diag(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                      logic [DATA_W-1:0] z);
        logic [DATA_W-1:0] e [9];
        for (int k = 0; k < 9; k++)
            e[k] = '0;
        e[0] = x; e[4] = y; e[8] = z;
        return make_matrix(e);
    endfunction

    function automatic t_in_item fill(logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] e [9];
        for (int k = 0; k < 9; k++)
            e[k] = x;
        return make_matrix(e);
    endfunction

    initial begin
        t_in_item directed[$];
        int sent;
        int burst;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(diag(ONE, ONE, ONE));
        directed.push_back(fill('0));
        directed.push_back(fill(MAXV));
        directed.push_back(fill(MINV));
        directed.push_back(diag(MAXV, MAXV, MAXV));
        directed.push_back(diag(MINV, MINV, MINV));
        directed.push_back(diag(MINV, MAXV, MINV));
        // Tiny determinant: one LSB on each diagonal gives a nonzero det below one LSB.
        directed.push_back(diag(32'd1, 32'd1, 32'd1));
        directed.push_back(diag(-ONE, ONE, ONE));
        directed.push_back(diag(ONE << 1, ONE << 2, -(ONE << 3)));
        directed.push_back(diag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(make_matrix('{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV}));
        directed.push_back(make_matrix('{ONE, ONE << 1, 32'd3 << 16, 32'd4 << 16,
                                         32'd5 << 16, 32'd6 << 16, 32'd7 << 16,
                                         32'd8 << 16, 32'd10 << 16}));
        directed.push_back(make_matrix('{'0, ONE, '0, '0, '0, ONE, ONE, '0, '0}));
        directed.push_back(make_matrix('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                                         32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC,
                                         32'h00FF_00FF, 32'hFF00_FF00, 32'h1234_5678}));
        foreach (directed[k])
            send_matrix(directed[k]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_matrix(random_matrix());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
